@@ sv/hdlcd_pkg.sv @@
// Shared types, constants and the CRC-16/X.25 byte update for the HDLC deframer.
// No dependencies; every other file imports this package.
package hdlcd_pkg;

	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE = 8'h7D;
	localparam logic [7:0] ESC_XOR = 8'h20;
	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam int HD_QUEUE_DEPTH = 2;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_CRC_ERROR = 2'd1,
		ST_TOO_SHORT = 2'd2
	} status_t;

	typedef struct packed {
		logic        verdict;
		logic        short_frame;
		logic [7:0]  data;
		logic [15:0] recv;
	} cmd_t;

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ sv/hdlcd_front.sv @@
// Front end: frame tracking, unstuffing and the two-byte hold; issues commands.
// Depends on hdlcd_pkg.
module hdlcd_front import hdlcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	output logic       cmd_valid,
	output cmd_t       cmd
);

	logic       in_frame_q;
	logic       esc_q;
	logic       nonempty_q;
	logic [1:0] cnt_q;
	logic [7:0] h0_q;
	logic [7:0] h1_q;

	logic       is_flag;
	logic       do_push;
	logic [7:0] push_val;

	assign is_flag = (rx_byte == FLAG_BYTE);

	always_comb begin
		do_push  = 1'b0;
		push_val = rx_byte;
		priority if (is_flag || !in_frame_q) begin
			do_push = 1'b0;
		end else if (esc_q) begin
			do_push  = 1'b1;
			push_val = rx_byte ^ ESC_XOR;
		end else if (rx_byte == ESC_BYTE) begin
			do_push = 1'b0;
		end else begin
			do_push = 1'b1;
		end
	end

	always_comb begin
		cmd_valid       = 1'b0;
		cmd.verdict     = KIND_VERDICT;
		cmd.short_frame = (cnt_q != 2'd2);
		cmd.data        = h0_q;
		cmd.recv        = {h1_q, h0_q};
		if (accept) begin
			if (is_flag) begin
				cmd_valid = in_frame_q && nonempty_q;
			end else if (do_push && cnt_q == 2'd2) begin
				cmd_valid   = 1'b1;
				cmd.verdict = KIND_PAYLOAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			nonempty_q <= 1'b0;
			cnt_q      <= 2'd0;
		end else if (accept) begin
			if (is_flag) begin
				in_frame_q <= 1'b1;
				esc_q      <= 1'b0;
				nonempty_q <= 1'b0;
				cnt_q      <= 2'd0;
			end else if (in_frame_q) begin
				if (esc_q) begin
					esc_q <= 1'b0;
				end else if (rx_byte == ESC_BYTE) begin
					esc_q <= 1'b1;
				end
				if (do_push) begin
					nonempty_q <= 1'b1;
					if (cnt_q != 2'd2) begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && do_push) begin
			unique case (cnt_q)
				2'd0: h0_q <= push_val;
				2'd1: h1_q <= push_val;
				default: begin
					h0_q <= h1_q;
					h1_q <= push_val;
				end
			endcase
		end
	end

endmodule

@@ sv/hdlcd_queue.sv @@
// Short command queue between the front end and the back end.
// Depends on hdlcd_pkg for the command type.
module hdlcd_queue import hdlcd_pkg::*; #(
	parameter int DEPTH = HD_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ sv/hdlcd_back.sv @@
// Back end: running CRC, verdict and the result output register.
// Depends on hdlcd_pkg.
module hdlcd_back import hdlcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  cmd_t       head_cmd,
	output logic       pop,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       kind,
	output logic [7:0] data_byte,
	output logic [1:0] status,
	output logic       last
);

	logic [15:0] crc_q;
	logic        valid_q;
	logic        kind_q;
	logic [7:0]  data_q;
	status_t     status_q;
	status_t     verdict;

	assign pop = head_valid && (!valid_q || !res_stall);

	always_comb begin
		priority if (head_cmd.short_frame) begin
			verdict = ST_TOO_SHORT;
		end else if (head_cmd.recv == ~crc_q) begin
			verdict = ST_OK;
		end else begin
			verdict = ST_CRC_ERROR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			crc_q   <= CRC_INIT;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				crc_q   <= head_cmd.verdict ? CRC_INIT : crc_fold(crc_q, head_cmd.data);
			end else if (!res_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= head_cmd.verdict;
			data_q   <= head_cmd.verdict ? 8'h00 : head_cmd.data;
			status_q <= head_cmd.verdict ? verdict : ST_OK;
		end
	end

	assign res_valid = valid_q;
	assign kind      = kind_q;
	assign data_byte = data_q;
	assign status    = status_q;
	assign last      = kind_q;

endmodule

@@ sv/hdlc_deframer_crc_check_core.sv @@
// HDLC deframer with CRC-16/X.25 check: front end, command queue, back end.
// Each command is written into the command queue, then popped into the registered result output.
// Throughput: one line byte per cycle; rx_stall rises only once the command queue
// is full because the result side is stalled.
// Reset (arst_n, asynchronous): out of frame, queue and output empty, CRC at 0xFFFF.
// Depends on hdlcd_pkg, hdlcd_front, hdlcd_queue and hdlcd_back.
module hdlc_deframer_crc_check_core import hdlcd_pkg::*; #(
	parameter int QUEUE_DEPTH = HD_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       kind,
	output logic [7:0] data_byte,
	output logic [1:0] status,
	output logic       last
);

	logic accept;
	logic cmd_valid;
	cmd_t cmd;
	logic full;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	assign rx_stall = full;
	assign accept   = rx_valid && !full;

	hdlcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	hdlcd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_valid),
		.push_cmd   (cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	hdlcd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.kind       (kind),
		.data_byte  (data_byte),
		.status     (status),
		.last       (last)
	);

endmodule

@@ sv/hdlcd_checker.sv @@
// Port-level checks for the HDLC deframer, bound to the top level.
// Depends on hdlcd_pkg and hdlc_deframer_crc_check_core.
module hdlcd_checker import hdlcd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_valid,
	input logic       rx_stall,
	input logic       res_valid,
	input logic       res_stall,
	input logic       kind,
	input logic [7:0] data_byte,
	input logic [1:0] status,
	input logic       last
);

	a_verdict_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_VERDICT |-> last && data_byte == 8'h00 &&
		(status == ST_OK || status == ST_CRC_ERROR || status == ST_TOO_SHORT))
		else $error("verdict item carries malformed fields");

	a_payload_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_PAYLOAD |-> !last && status == ST_OK)
		else $error("payload item carries verdict fields");

	a_no_input_stall_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !rx_stall)
		else $error("input stalled while the output is empty");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(kind) && $stable(data_byte) &&
		$stable(status) && $stable(last))
		else $error("stalled result changed");

endmodule

bind hdlc_deframer_crc_check_core hdlcd_checker u_hdlcd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rx_valid  (rx_valid),
	.rx_stall  (rx_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.kind      (kind),
	.data_byte (data_byte),
	.status    (status),
	.last      (last)
);

@@ tb/tb_hdlc_deframer_crc_check_core.sv @@
// Self-checking testbench for hdlc_deframer_crc_check_core: line bytes are sent and the
// deframed payload and frame verdicts are checked against a behavioural X.25 deframer.
// Depends on hdlcd_pkg and hdlc_deframer_crc_check_core.
module tb_hdlc_deframer_crc_check_core;
	import hdlcd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1700;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [1:0] status;
		logic       last;
	} deframed_t;

	typedef enum logic [1:0] {
		PIN_PREDICT,
		PIN_NONE,
		PIN_VERDICT
	} pin_t;

	typedef struct packed {
		logic [7:0] line;
		pin_t       pin;
		status_t    verdict;
	} row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       rx_valid = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic       res_stall = 1'b0;
	logic       rx_stall;
	logic       res_valid;
	logic       kind;
	logic [7:0] data_byte;
	logic [1:0] status;
	logic       last;

	bit          in_frm = 1'b0;
	bit          esc_pend = 1'b0;
	bit          frm_has_data = 1'b0;
	logic [15:0] crc_acc = CRC_INIT;
	logic [7:0]  hold0 = 8'h00;
	logic [7:0]  hold1 = 8'h00;
	int unsigned hold_n = 0;
	deframed_t   deframed_q [$];

	int unsigned line_bytes_taken = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_cnt = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_trigger = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;

	row_t directed_rows [0:22] = '{
		'{8'h00, PIN_NONE, ST_OK},
		'{8'hFF, PIN_NONE, ST_OK},
		'{8'h7D, PIN_NONE, ST_OK},
		'{8'h7E, PIN_NONE, ST_OK},
		'{8'h7E, PIN_NONE, ST_OK},
		'{8'h41, PIN_NONE, ST_OK},
		'{8'h7E, PIN_VERDICT, ST_TOO_SHORT},
		'{8'h7D, PIN_NONE, ST_OK},
		'{8'h7E, PIN_NONE, ST_OK},
		'{8'h00, PIN_NONE, ST_OK},
		'{8'h00, PIN_NONE, ST_OK},
		'{8'h7E, PIN_VERDICT, ST_OK},
		'{8'h00, PIN_NONE, ST_OK},
		'{8'h01, PIN_NONE, ST_OK},
		'{8'h7E, PIN_VERDICT, ST_CRC_ERROR},
		'{8'hFF, PIN_NONE, ST_OK},
		'{8'h7D, PIN_NONE, ST_OK},
		'{8'h7D, PIN_PREDICT, ST_OK},
		'{8'h7D, PIN_PREDICT, ST_OK},
		'{8'h5E, PIN_PREDICT, ST_OK},
		'{8'h7D, PIN_PREDICT, ST_OK},
		'{8'hDF, PIN_PREDICT, ST_OK},
		'{8'h7E, PIN_PREDICT, ST_OK}
	};

	hdlc_deframer_crc_check_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.kind(kind),
		.data_byte(data_byte),
		.status(status),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] x25_fold(input logic [15:0] acc, input logic [7:0] octet);
		logic [15:0] r;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			if (r[0] ^ octet[i])
				r = (r >> 1) ^ CRC_POLY;
			else
				r = r >> 1;
		end
		return r;
	endfunction

	task automatic queue_expected(input deframed_t r);
		deframed_q.insert(deframed_q.size(), r);
	endtask

	task automatic deframe_step(input logic [7:0] b, output bit produced, output deframed_t r);
		logic [7:0] v;
		produced = 1'b0;
		r = '0;
		if (b == FLAG_BYTE) begin
			if (in_frm && frm_has_data) begin
				produced = 1'b1;
				r.kind = KIND_VERDICT;
				r.last = 1'b1;
				if (hold_n < 2)
					r.status = ST_TOO_SHORT;
				else if ({hold1, hold0} == ~crc_acc)
					r.status = ST_OK;
				else
					r.status = ST_CRC_ERROR;
			end
			in_frm = 1'b1;
			esc_pend = 1'b0;
			crc_acc = CRC_INIT;
			hold0 = 8'h00;
			hold1 = 8'h00;
			hold_n = 0;
			frm_has_data = 1'b0;
		end else if (in_frm) begin
			if (!esc_pend && b == ESC_BYTE) begin
				esc_pend = 1'b1;
			end else begin
				v = esc_pend ? (b ^ ESC_XOR) : b;
				esc_pend = 1'b0;
				frm_has_data = 1'b1;
				if (hold_n < 2) begin
					if (hold_n == 0)
						hold0 = v;
					else
						hold1 = v;
					hold_n++;
				end else begin
					produced = 1'b1;
					r.kind = KIND_PAYLOAD;
					r.data = hold0;
					crc_acc = x25_fold(crc_acc, hold0);
					hold0 = hold1;
					hold1 = v;
				end
			end
		end
	endtask

	task automatic push_line_byte(input logic [7:0] b, input pin_t pin, input status_t pinned);
		bit        produced;
		deframed_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (rx_stall)
			@(posedge clk);
		if (in_frm || b == FLAG_BYTE)
			line_bytes_taken++;
		deframe_step(b, produced, r);
		if (pin == PIN_VERDICT)
			queue_expected('{KIND_VERDICT, 8'h00, pinned, 1'b1});
		else if (pin == PIN_PREDICT && produced)
			queue_expected(r);
	endtask

	function automatic logic [7:0] pick_octet();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(3))
				0: b = FLAG_BYTE;
				1: b = ESC_BYTE;
				2: b = FLAG_BYTE ^ ESC_XOR;
				default: b = ESC_BYTE ^ ESC_XOR;
			endcase
		end
		return b;
	endfunction

	task automatic send_random_frame();
		logic [7:0]  body [$];
		logic [15:0] acc;
		logic [7:0]  b;
		int          len;
		int          mode;
		int          idx;
		mode = $urandom_range(99);
		len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
		acc = CRC_INIT;
		for (int i = 0; i < len; i++) begin
			b = pick_octet();
			body.insert(body.size(), b);
			acc = x25_fold(acc, b);
		end
		if (mode < 75) begin
			body.insert(body.size(), ~acc[7:0]);
			body.insert(body.size(), ~acc[15:8]);
			if (mode >= 60) begin
				idx = $urandom_range(body.size() - 1);
				body[idx] = body[idx] ^ (8'h01 << $urandom_range(7));
			end
		end
		if (mode >= 85 && mode < 95) begin
			for (int i = 0; i < len + 2; i++) begin
				b = ($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? FLAG_BYTE : ESC_BYTE)
					: pick_octet();
				push_line_byte(b, PIN_PREDICT, ST_OK);
			end
		end else begin
			foreach (body[i]) begin
				if (body[i] == FLAG_BYTE || body[i] == ESC_BYTE
						|| ($urandom_range(15) == 0 && (body[i] ^ ESC_XOR) != FLAG_BYTE)) begin
					push_line_byte(ESC_BYTE, PIN_PREDICT, ST_OK);
					push_line_byte(body[i] ^ ESC_XOR, PIN_PREDICT, ST_OK);
				end else begin
					push_line_byte(body[i], PIN_PREDICT, ST_OK);
				end
			end
			if (mode >= 95)
				push_line_byte(ESC_BYTE, PIN_PREDICT, ST_OK);
		end
		push_line_byte(FLAG_BYTE, PIN_PREDICT, ST_OK);
	endtask

	task automatic check_deframed();
		deframed_t want;
		deframed_t got;
		got = '{kind, data_byte, status, last};
		if (deframed_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected item: kind %0d data %02h status %0d last %0d",
					got.kind, got.data, got.status, got.last);
		end else begin
			want = deframed_q.pop_front();
			if (got.kind !== want.kind || got.data !== want.data
					|| got.status !== want.status || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected kind %0d data %02h status %0d last %0d, ",
						want.kind, want.data, want.status, want.last,
						"got kind %0d data %02h status %0d last %0d",
						got.kind, got.data, got.status, got.last);
			end
		end
	endtask

	always @(posedge clk) begin
		if (hold_trigger != hold_seen) begin
			hold_seen = hold_trigger;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (arst_n && res_valid && !res_stall)
			check_deframed();
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_hdlc_deframer_crc_check_core: errors");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			push_line_byte(directed_rows[i].line, directed_rows[i].pin, directed_rows[i].verdict);
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					hold_trigger++;
				end
				1: begin
					send_idle_pct = 51;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 51;
				end
				default: begin
					send_idle_pct = 17;
					recv_stall_pct = 17;
				end
			endcase
			while (line_bytes_taken < (p + 1) * RANDOM_ITEMS / 4 + 25)
				send_random_frame();
			rx_valid <= 1'b0;
			while (deframed_q.size() != 0)
				@(posedge clk);
			repeat (8) @(posedge clk);
		end
		if (mismatches == 0)
			$display("tb_hdlc_deframer_crc_check_core: clean");
		else
			$display("tb_hdlc_deframer_crc_check_core: errors");
		$finish;
	end

endmodule
